@@ rtl/disk_block_command_queue_top_assert.svh @@
// Assertion macros used by the checker file of the command queue.
`ifndef DISK_BLOCK_COMMAND_QUEUE_TOP_ASSERT_SVH
`define DISK_BLOCK_COMMAND_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DBCQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DBCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dbcq_pkg.sv @@
`default_nettype none

package dbcq_pkg;

  // Field widths of the words on the channels.
  localparam int REQ_TYPE_W = 2;
  localparam int DEV_W      = 2;
  localparam int BLK_W      = 32;
  localparam int ACTION_W   = 4;
  localparam int LBA_W      = 48;
  localparam int SCNT_W     = 2;
  localparam int CMD_CODE_W = 8;
  localparam int MASK_W     = 4;

  // Defaults for the top-level parameters.
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int NUM_DEVICES_DEF = 4;

  // Depth of the command queue between the front and the back.
  localparam int CMD_FIFO_DEPTH = 2;

  // ATA opcodes and the transfer size of one block.
  localparam logic [CMD_CODE_W-1:0] CMD_RD_EXT        = 8'h24;
  localparam logic [CMD_CODE_W-1:0] CMD_WR_EXT        = 8'h34;
  localparam logic [SCNT_W-1:0]     SECTORS_PER_BLOCK = 2'd2;

  // Request type codes on the input word.
  typedef enum logic [REQ_TYPE_W-1:0] {
    RT_READ    = 2'd0,
    RT_WRITE   = 2'd1,
    RT_IRQ     = 2'd2,
    RT_UNKNOWN = 2'd3
  } req_type_t;

  // Action codes on the result word.
  typedef enum logic [ACTION_W-1:0] {
    ACT_REJECT      = 4'd0,
    ACT_FULL        = 4'd1,
    ACT_QUEUED      = 4'd2,
    ACT_ISSUE_RD    = 4'd3,
    ACT_ISSUE_WR    = 4'd4,
    ACT_DONE_RD     = 4'd5,
    ACT_DONE_WR     = 4'd6,
    ACT_IRQ_DROP    = 4'd7,
    ACT_IRQ_INVALID = 4'd8,
    ACT_IRQ_EMPTY   = 4'd9
  } action_t;

  // Class the front gives each word.
  typedef enum logic [1:0] {
    CK_REJECT,
    CK_IRQ_INVALID,
    CK_ENQ,
    CK_IRQ
  } cmd_kind_t;

  // Classified command passed from the front to the back.
  typedef struct packed {
    cmd_kind_t         kind;
    logic              wr;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
  } cmd_t;

  // One stored queue entry.
  typedef struct packed {
    logic              wr;
    logic [BLK_W-1:0]  blk;
  } entry_t;

  // Sequencer states of the back.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_DONE,
    BK_NEXT
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/dbcq_in_if.sv @@
`default_nettype none

// Request channel: read and write requests and device interrupts.
interface dbcq_in_if import dbcq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [DEV_W-1:0]      device;
  logic [BLK_W-1:0]      block_num;

  modport source (output valid, output req_type, output device, output block_num,
                  input ready);
  modport sink (input valid, input req_type, input device, input block_num,
                output ready);
endinterface

`default_nettype wire

@@ rtl/dbcq_out_if.sv @@
`default_nettype none

// Result channel: one word per action taken.
interface dbcq_out_if import dbcq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [DEV_W-1:0]      dev_out;
  logic [LBA_W-1:0]      lba;
  logic [SCNT_W-1:0]     sector_count;
  logic [CMD_CODE_W-1:0] command_code;
  logic [BLK_W-1:0]      done_block;
  logic                  last;

  modport source (output valid, output action, output dev_out, output lba,
                  output sector_count, output command_code, output done_block,
                  output last, input ready);
  modport sink (input valid, input action, input dev_out, input lba,
                input sector_count, input command_code, input done_block,
                input last, output ready);
endinterface

`default_nettype wire

@@ rtl/dbcq_front.sv @@
`default_nettype none

module dbcq_front
  import dbcq_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_wdata,
  dbcq_in_if.sink                in_req,
  output logic                   cmd_valid,
  input  wire logic              cmd_ready,
  output cmd_t                   cmd_data
);

  localparam logic [DEV_W:0] NDEV_LIMIT = (DEV_W+1)'(NUM_DEVICES);

  logic [MASK_W-1:0] mask_r;
  logic              dev_ok;

  // Device valid mask register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_we) begin
      mask_r <= cfg_wdata;
    end
  end

  // A device is usable when it exists and probe marked it.
  assign dev_ok = ({1'b0, in_req.device} < NDEV_LIMIT) && mask_r[in_req.device];

  // Classify the incoming word.
  always_comb begin
    cmd_data.dev = in_req.device;
    cmd_data.blk = in_req.block_num;
    cmd_data.wr  = (in_req.req_type == RT_WRITE);
    unique case (in_req.req_type)
      RT_READ, RT_WRITE: cmd_data.kind = dev_ok ? CK_ENQ : CK_REJECT;
      RT_IRQ:            cmd_data.kind = dev_ok ? CK_IRQ : CK_IRQ_INVALID;
      default:           cmd_data.kind = CK_REJECT;
    endcase
  end

  // Words pass straight into the command queue.
  assign cmd_valid    = in_req.valid;
  assign in_req.ready = cmd_ready;

endmodule

`default_nettype wire

@@ rtl/dbcq_cmd_fifo.sv @@
`default_nettype none

module dbcq_cmd_fifo
  import dbcq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  cmd_t      push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output cmd_t      pop_data
);

  localparam int PTR_W = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_FIFO_DEPTH);

  cmd_t             slot_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != CNT_FULL);
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage slots.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/dbcq_back.sv @@
`default_nettype none

module dbcq_back
  import dbcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  dbcq_out_if.source out_res
);

  localparam int IDX_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIX_W      = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int NDEV_SLOTS = 1 << DIX_W;
  localparam int ADDR_W     = DIX_W + IDX_W;
  localparam int MEM_DEPTH  = 1 << ADDR_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  back_state_t      state_r;
  back_state_t      state_nxt;
  cmd_t             cmd_r;

  // Per-device ring pointers, fill counts and discard flags.
  logic [IDX_W-1:0] head_r    [NDEV_SLOTS];
  logic [IDX_W-1:0] tail_r    [NDEV_SLOTS];
  logic [CNT_W-1:0] count_r   [NDEV_SLOTS];
  logic             discard_r [NDEV_SLOTS];

  // Queue entry memory, one region per device.
  entry_t           mem [MEM_DEPTH];
  entry_t           rd_entry_r;

  logic             out_valid_r;
  action_t          out_action_r;
  logic [DEV_W-1:0] out_dev_r;
  logic [LBA_W-1:0] out_lba_r;
  logic [SCNT_W-1:0] out_scnt_r;
  logic [CMD_CODE_W-1:0] out_code_r;
  logic [BLK_W-1:0] out_blk_r;
  logic             out_last_r;

  logic [DEV_W:0]   dev_ext;
  logic [DIX_W-1:0] dix;
  logic [IDX_W-1:0] head_cur;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] tail_cur;
  logic [IDX_W-1:0] tail_inc;
  logic [CNT_W-1:0] cnt_cur;
  logic             disc_cur;
  logic             slot_free;
  logic             irq_fetch;

  logic             emit;
  action_t          res_action;
  logic             res_issue;
  logic             res_done;
  entry_t           res_entry;
  logic             res_last;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_ridx;
  logic             head_adv;
  logic             tail_adv;
  logic             cnt_inc;
  logic             cnt_dec;
  logic             disc_clr;
  logic             disc_set;

  // Per-device state of the command in hand.
  assign dev_ext   = {1'b0, cmd_r.dev};
  assign dix       = dev_ext[DIX_W-1:0];
  assign head_cur  = head_r[dix];
  assign tail_cur  = tail_r[dix];
  assign cnt_cur   = count_r[dix];
  assign disc_cur  = discard_r[dix];
  assign head_inc  = (head_cur == IDX_LAST) ? '0 : head_cur + 1'b1;
  assign tail_inc  = (tail_cur == IDX_LAST) ? '0 : tail_cur + 1'b1;
  assign slot_free = !out_valid_r || out_res.ready;
  assign irq_fetch = (cmd_r.kind == CK_IRQ) && !disc_cur && (cnt_cur != '0);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        if (irq_fetch) begin
          state_nxt = BK_DONE;
        end else if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          state_nxt = (cnt_cur == CNT_ONE) ? BK_IDLE : BK_NEXT;
        end
      end
      BK_NEXT: begin
        if (slot_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Results, memory accesses and state updates for each step.
  always_comb begin
    cmd_ready  = 1'b0;
    emit       = 1'b0;
    res_action = ACT_REJECT;
    res_issue  = 1'b0;
    res_done   = 1'b0;
    res_entry  = rd_entry_r;
    res_last   = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_ridx   = head_cur;
    head_adv   = 1'b0;
    tail_adv   = 1'b0;
    cnt_inc    = 1'b0;
    cnt_dec    = 1'b0;
    disc_clr   = 1'b0;
    disc_set   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_ready = 1'b1;
      end
      BK_EXEC: begin
        unique case (cmd_r.kind)
          CK_REJECT: begin
            emit       = slot_free;
            res_action = ACT_REJECT;
          end
          CK_IRQ_INVALID: begin
            emit       = slot_free;
            res_action = ACT_IRQ_INVALID;
          end
          CK_ENQ: begin
            emit      = slot_free;
            res_entry = '{wr: cmd_r.wr, blk: cmd_r.blk};
            if (cnt_cur >= CNT_FULL) begin
              res_action = ACT_FULL;
            end else begin
              mem_we   = slot_free;
              tail_adv = slot_free;
              cnt_inc  = slot_free;
              if (cnt_cur == '0) begin
                res_action = cmd_r.wr ? ACT_ISSUE_WR : ACT_ISSUE_RD;
                res_issue  = 1'b1;
              end else begin
                res_action = ACT_QUEUED;
              end
            end
          end
          default: begin
            if (disc_cur) begin
              emit       = slot_free;
              disc_clr   = slot_free;
              res_action = ACT_IRQ_DROP;
            end else if (cnt_cur == '0) begin
              emit       = slot_free;
              res_action = ACT_IRQ_EMPTY;
            end else begin
              // Fetch the head entry; the result goes out next step.
              mem_re   = 1'b1;
              mem_ridx = head_cur;
            end
          end
        endcase
      end
      BK_DONE: begin
        emit       = slot_free;
        res_action = rd_entry_r.wr ? ACT_DONE_WR : ACT_DONE_RD;
        res_done   = 1'b1;
        res_last   = (cnt_cur == CNT_ONE);
        head_adv   = slot_free;
        cnt_dec    = slot_free;
        disc_set   = slot_free && rd_entry_r.wr;
        // Fetch the new head when more entries wait.
        mem_re     = slot_free && (cnt_cur != CNT_ONE);
        mem_ridx   = head_inc;
      end
      BK_NEXT: begin
        emit       = slot_free;
        res_action = rd_entry_r.wr ? ACT_ISSUE_WR : ACT_ISSUE_RD;
        res_issue  = 1'b1;
      end
      default: begin
        cmd_ready = 1'b0;
      end
    endcase
  end

  // Sequencer state and the command in hand.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      cmd_r <= cmd_data;
    end
  end

  // Per-device queue bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NDEV_SLOTS; i++) begin
        head_r[i]    <= '0;
        tail_r[i]    <= '0;
        count_r[i]   <= '0;
        discard_r[i] <= 1'b1;
      end
    end else begin
      if (head_adv) begin
        head_r[dix] <= head_inc;
      end
      if (tail_adv) begin
        tail_r[dix] <= tail_inc;
      end
      if (cnt_inc) begin
        count_r[dix] <= cnt_cur + 1'b1;
      end else if (cnt_dec) begin
        count_r[dix] <= cnt_cur - 1'b1;
      end
      if (disc_clr) begin
        discard_r[dix] <= 1'b0;
      end else if (disc_set) begin
        discard_r[dix] <= 1'b1;
      end
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{dix, tail_cur}] <= '{wr: cmd_r.wr, blk: cmd_r.blk};
    end
    if (mem_re) begin
      rd_entry_r <= mem[{dix, mem_ridx}];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_action_r <= res_action;
      out_dev_r    <= cmd_r.dev;
      out_lba_r    <= res_issue ? LBA_W'({res_entry.blk, 1'b0}) : '0;
      out_scnt_r   <= res_issue ? SECTORS_PER_BLOCK : '0;
      out_code_r   <= res_issue ? (res_entry.wr ? CMD_WR_EXT : CMD_RD_EXT) : '0;
      out_blk_r    <= (res_issue || res_done) ? res_entry.blk : '0;
      out_last_r   <= res_last;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.action       = out_action_r;
  assign out_res.dev_out      = out_dev_r;
  assign out_res.lba          = out_lba_r;
  assign out_res.sector_count = out_scnt_r;
  assign out_res.command_code = out_code_r;
  assign out_res.done_block   = out_blk_r;
  assign out_res.last         = out_last_r;

endmodule

`default_nettype wire

@@ rtl/disk_block_command_queue_top.sv @@
// Channel   Direction  Contents
// in_req    in         req_type, device, block_num
// out_res   out        action, dev_out, lba, sector_count, command_code,
//                      done_block, last
// cfg       in         cfg_we, cfg_wdata (device valid mask)
//
// After it leaves the command queue, a request is picked up by the back sequencer in its
// idle state; the execute state then updates the queue memory and emits its result.
// An interrupt that completes an entry also passes the done state, and the next state
// when it issues the next entry, because each entry fetch waits on the registered read.
// Reset is synchronous and active low; it empties all queues and sets every discard flag.
// A stalled result holds in the output register while the front keeps taking words
// into the two-entry command queue.
`default_nettype none

module disk_block_command_queue_top
  import dbcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int NUM_DEVICES = NUM_DEVICES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [MASK_W-1:0] cfg_wdata,
  dbcq_in_if.sink                in_req,
  dbcq_out_if.source             out_res
);

  logic cf_push_valid;
  logic cf_push_ready;
  cmd_t cf_push_data;
  logic cf_pop_valid;
  logic cf_pop_ready;
  cmd_t cf_pop_data;

  // Front: device mask register and classification.
  dbcq_front #(
    .NUM_DEVICES(NUM_DEVICES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd_valid (cf_push_valid),
    .cmd_ready (cf_push_ready),
    .cmd_data  (cf_push_data)
  );

  // Command queue between the two halves.
  dbcq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cf_push_valid),
    .push_ready (cf_push_ready),
    .push_data  (cf_push_data),
    .pop_valid  (cf_pop_valid),
    .pop_ready  (cf_pop_ready),
    .pop_data   (cf_pop_data)
  );

  // Back: per-device queues and the command channel.
  dbcq_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .NUM_DEVICES(NUM_DEVICES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cf_pop_valid),
    .cmd_ready (cf_pop_ready),
    .cmd_data  (cf_pop_data),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire

@@ rtl/dbcq_checker.sv @@
`default_nettype none

`include "disk_block_command_queue_top_assert.svh"

module dbcq_checker
  import dbcq_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [ACTION_W-1:0]   action,
  input wire logic [LBA_W-1:0]      lba,
  input wire logic [SCNT_W-1:0]     sector_count,
  input wire logic [CMD_CODE_W-1:0] command_code,
  input wire logic [BLK_W-1:0]      done_block,
  input wire logic                  last
);

  logic is_issue;

  assign is_issue = (action == ACT_ISSUE_RD) || (action == ACT_ISSUE_WR);

  // A stalled result word keeps its contents.
  `DBCQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(action) && $stable(done_block) && $stable(last), "result word changed while stalled")

  // An issue carries a consistent LBA48 command.
  `DBCQ_ASSERT_NOW(a_issue_fields, clk, rst_n, out_valid && is_issue, (sector_count == SECTORS_PER_BLOCK) && (lba == LBA_W'({done_block, 1'b0})) && (command_code == ((action == ACT_ISSUE_WR) ? CMD_WR_EXT : CMD_RD_EXT)), "issue fields inconsistent")

  // Other actions leave the command fields clear.
  `DBCQ_ASSERT_NOW(a_plain_fields, clk, rst_n, out_valid && !is_issue, (sector_count == '0) && (command_code == '0) && (lba == '0), "command fields set on a non-issue action")

  // Only a completion can be followed by a second result.
  `DBCQ_ASSERT_NOW(a_two_results, clk, rst_n, out_valid && !last, (action == ACT_DONE_RD) || (action == ACT_DONE_WR), "non-final result on an action other than a completion")

endmodule

bind disk_block_command_queue_top dbcq_checker u_dbcq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_res.valid),
  .out_ready    (out_res.ready),
  .action       (out_res.action),
  .lba          (out_res.lba),
  .sector_count (out_res.sector_count),
  .command_code (out_res.command_code),
  .done_block   (out_res.done_block),
  .last         (out_res.last)
);

`default_nettype wire

@@ verif/tb_disk_block_command_queue_top.sv @@
`default_nettype none

module tb_disk_block_command_queue_top
  import dbcq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = QUEUE_DEPTH_DEF;
  localparam int DEVICES    = NUM_DEVICES_DEF;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_WAIT  = 20;

  // One word on the result channel, as the predictor expects it.
  typedef struct packed {
    action_t               action;
    logic [DEV_W-1:0]      dev;
    logic [LBA_W-1:0]      lba;
    logic [SCNT_W-1:0]     sectors;
    logic [CMD_CODE_W-1:0] opcode;
    logic [BLK_W-1:0]      blk;
    logic                  last;
  } disk_result_t;

  // One row of the directed part. Rows with pinned set carry their result by hand.
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    req_type_t         kind;
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic              pinned;
    action_t           want;
  } stim_row_t;

  // Mask and idling pattern of one random phase.
  typedef struct {
    logic [MASK_W-1:0] mask;
    int                idle_pct;
    int                stall_pct;
    int                count;
  } phase_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [MASK_W-1:0] cfg_wdata;

  dbcq_in_if  req_ch ();
  dbcq_out_if res_ch ();

  disk_block_command_queue_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_req   (req_ch),
    .out_res  (res_ch)
  );

  // Predictor state: one ring per device plus the discard flags and the mask.
  entry_t            slot_mem  [DEVICES][DEPTH];
  int unsigned       slot_head [DEVICES];
  int unsigned       slot_tail [DEVICES];
  int unsigned       slot_fill [DEVICES];
  bit                skip_irq  [DEVICES];
  logic [MASK_W-1:0] usable_mask;

  disk_result_t pending_results [$];
  int           mismatches = 0;
  int           sender_idle_pct = 0;
  int           recv_stall_pct = 0;

  stim_row_t directed_rows [21] = '{
    '{4'h0,    RT_READ,    2'd0, 32'h0000_0000, 1'b1, ACT_REJECT},
    '{4'h0,    RT_IRQ,     2'd3, 32'h0000_0000, 1'b1, ACT_IRQ_INVALID},
    '{4'h0,    RT_UNKNOWN, 2'd2, 32'hFFFF_FFFF, 1'b1, ACT_REJECT},
    '{4'hF,    RT_IRQ,     2'd0, 32'h0000_0000, 1'b1, ACT_IRQ_DROP},
    '{4'hF,    RT_IRQ,     2'd0, 32'h0000_0000, 1'b1, ACT_IRQ_EMPTY},
    '{4'hF,    RT_READ,    2'd0, 32'hFFFF_FFFF, 1'b0, ACT_REJECT},
    '{4'hF,    RT_WRITE,   2'd0, 32'h0000_0000, 1'b1, ACT_QUEUED},
    '{4'hF,    RT_WRITE,   2'd0, 32'h8000_0001, 1'b1, ACT_QUEUED},
    '{4'hF,    RT_IRQ,     2'd0, 32'h0000_0000, 1'b0, ACT_REJECT},
    '{4'hF,    RT_IRQ,     2'd0, 32'hFFFF_FFFF, 1'b0, ACT_REJECT},
    '{4'hF,    RT_IRQ,     2'd0, 32'h0000_0000, 1'b1, ACT_IRQ_DROP},
    '{4'hF,    RT_IRQ,     2'd0, 32'h0000_0000, 1'b0, ACT_REJECT},
    '{4'hF,    RT_UNKNOWN, 2'd1, 32'h0000_0005, 1'b1, ACT_REJECT},
    '{4'hF,    RT_WRITE,   2'd3, 32'h1234_5678, 1'b0, ACT_REJECT},
    '{4'b0101, RT_READ,    2'd3, 32'h0000_0001, 1'b1, ACT_REJECT},
    '{4'b0101, RT_IRQ,     2'd3, 32'h0000_0000, 1'b1, ACT_IRQ_INVALID},
    '{4'b1010, RT_IRQ,     2'd3, 32'h0000_0000, 1'b1, ACT_IRQ_DROP},
    '{4'b1010, RT_IRQ,     2'd3, 32'h0000_0000, 1'b0, ACT_REJECT},
    '{4'b1010, RT_IRQ,     2'd1, 32'h0000_0000, 1'b1, ACT_IRQ_DROP},
    '{4'b1010, RT_READ,    2'd1, 32'h0000_0002, 1'b0, ACT_REJECT},
    '{4'b1010, RT_IRQ,     2'd2, 32'h0000_0000, 1'b1, ACT_IRQ_INVALID}
  };

  phase_t phases [5] = '{
    '{4'hF,    0,  0,  300},
    '{4'b0110, 56, 0,  300},
    '{4'h0,    0,  56, 80},
    '{4'hF,    0,  56, 320},
    '{4'b1011, 33, 33, 330}
  };

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Builds one result word; issue and done decide which payload fields are live.
  function automatic disk_result_t shape_result(action_t act, logic [DEV_W-1:0] d,
                                                entry_t e, bit issue, bit done);
    disk_result_t r;
    r = '0;
    r.action = act;
    r.dev = d;
    if (issue) begin
      r.lba = {15'b0, e.blk, 1'b0};
      r.sectors = SECTORS_PER_BLOCK;
      r.opcode = e.wr ? CMD_WR_EXT : CMD_RD_EXT;
    end
    if (issue || done) begin
      r.blk = e.blk;
    end
    return r;
  endfunction

  // Command for the entry now at the head of a device's ring.
  function automatic disk_result_t head_issue(logic [DEV_W-1:0] d);
    entry_t e;
    e = slot_mem[d][slot_head[d]];
    return shape_result(e.wr ? ACT_ISSUE_WR : ACT_ISSUE_RD, d, e, 1'b1, 1'b0);
  endfunction

  // Works out the results of one accepted word and advances the predictor state.
  function automatic void predict_command(input req_type_t kind, input logic [DEV_W-1:0] d,
                                          input logic [BLK_W-1:0] b,
                                          ref disk_result_t outs[$]);
    entry_t       e;
    disk_result_t r;
    bit           usable;
    e = '0;
    usable = usable_mask[d];
    outs.delete();
    case (kind)
      RT_UNKNOWN: begin
        outs.push_back(shape_result(ACT_REJECT, d, e, 1'b0, 1'b0));
      end
      RT_IRQ: begin
        if (!usable) begin
          outs.push_back(shape_result(ACT_IRQ_INVALID, d, e, 1'b0, 1'b0));
        end else if (skip_irq[d]) begin
          skip_irq[d] = 1'b0;
          outs.push_back(shape_result(ACT_IRQ_DROP, d, e, 1'b0, 1'b0));
        end else if (slot_fill[d] == 0) begin
          outs.push_back(shape_result(ACT_IRQ_EMPTY, d, e, 1'b0, 1'b0));
        end else begin
          // Complete the head entry; a write is followed by a flush interrupt.
          e = slot_mem[d][slot_head[d]];
          slot_head[d] = (slot_head[d] + 1) % DEPTH;
          slot_fill[d]--;
          if (e.wr) begin
            skip_irq[d] = 1'b1;
          end
          outs.push_back(shape_result(e.wr ? ACT_DONE_WR : ACT_DONE_RD, d, e, 1'b0, 1'b1));
          if (slot_fill[d] > 0) begin
            outs.push_back(head_issue(d));
          end
        end
      end
      default: begin
        if (!usable) begin
          outs.push_back(shape_result(ACT_REJECT, d, e, 1'b0, 1'b0));
        end else if (slot_fill[d] >= DEPTH) begin
          outs.push_back(shape_result(ACT_FULL, d, e, 1'b0, 1'b0));
        end else begin
          slot_mem[d][slot_tail[d]] = {kind == RT_WRITE, b};
          slot_tail[d] = (slot_tail[d] + 1) % DEPTH;
          slot_fill[d]++;
          if (slot_fill[d] == 1) begin
            outs.push_back(head_issue(d));
          end else begin
            outs.push_back(shape_result(ACT_QUEUED, d, e, 1'b0, 1'b0));
          end
        end
      end
    endcase
    r = outs.pop_back();
    r.last = 1'b1;
    outs.push_back(r);
  endfunction

  // Offers one word, waits for it to be taken and records what it should produce.
  task automatic send_word(req_type_t kind, logic [DEV_W-1:0] d, logic [BLK_W-1:0] b,
                           bit pinned, action_t want);
    disk_result_t outs [$];
    disk_result_t hand;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.device <= d;
    req_ch.block_num <= b;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    predict_command(kind, d, b, outs);
    if (pinned) begin
      hand = '0;
      hand.action = want;
      hand.dev = d;
      hand.last = 1'b1;
      pending_results.push_back(hand);
    end else begin
      foreach (outs[i]) begin
        pending_results.push_back(outs[i]);
      end
    end
  endtask

  // Stops offering words and waits until every expected result has arrived.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes the device mask; only called while the block is idle.
  task automatic write_mask(logic [MASK_W-1:0] m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    usable_mask = m;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [BLK_W-1:0] random_block();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return $urandom;
  endfunction

  // Picks a usable device when there is one.
  function automatic logic [DEV_W-1:0] pick_device();
    logic [DEV_W-1:0] d;
    d = DEV_W'($urandom_range(DEVICES - 1));
    if (usable_mask != '0) begin
      while (!usable_mask[d]) begin
        d = DEV_W'($urandom_range(DEVICES - 1));
      end
    end
    return d;
  endfunction

  // Mostly well-formed requests and interrupts to usable devices, some noise,
  // and one burst that runs a queue past full.
  task automatic run_random(int n_items);
    int               sent;
    int               roll;
    req_type_t        kind;
    logic [DEV_W-1:0] d;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      d = pick_device();
      if (sent == n_items / 3) begin
        repeat (DEPTH + 3) begin
          kind = $urandom_range(1) ? RT_WRITE : RT_READ;
          send_word(kind, d, random_block(), 1'b0, ACT_REJECT);
        end
        sent += DEPTH + 3;
      end else begin
        if (roll < 40) begin
          kind = RT_IRQ;
        end else if (roll < 80) begin
          kind = $urandom_range(1) ? RT_WRITE : RT_READ;
        end else begin
          kind = req_type_t'($urandom_range(3));
          d = DEV_W'($urandom_range(DEVICES - 1));
        end
        send_word(kind, d, random_block(), 1'b0, ACT_REJECT);
        sent++;
      end
    end
  endtask

  task automatic compare_field(string label, logic [LBA_W-1:0] want, logic [LBA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stalls, and each accepted word is checked against the oldest
  // expectation.
  always @(posedge clk) begin : check_results
    disk_result_t want;
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got action %0d dev %0d",
                 $time, res_ch.action, res_ch.dev_out);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("action", LBA_W'(want.action), LBA_W'(res_ch.action));
        compare_field("dev_out", LBA_W'(want.dev), LBA_W'(res_ch.dev_out));
        compare_field("lba", want.lba, res_ch.lba);
        compare_field("sector_count", LBA_W'(want.sectors), LBA_W'(res_ch.sector_count));
        compare_field("command_code", LBA_W'(want.opcode), LBA_W'(res_ch.command_code));
        compare_field("done_block", LBA_W'(want.blk), LBA_W'(res_ch.done_block));
        compare_field("last", LBA_W'(want.last), LBA_W'(res_ch.last));
      end
    end
  end

  // Watchdog: ends the run after too many cycles with no word moving on either channel.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[disk_block_command_queue_top] ERROR");
    $finish;
  end

  // Stimulus: reset, directed rows, then the random phases.
  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= RT_READ;
    req_ch.device <= '0;
    req_ch.block_num <= '0;

    // Predictor reset: empty rings, every discard flag set, no usable device.
    usable_mask = '0;
    for (int d = 0; d < DEVICES; d++) begin
      slot_head[d] = 0;
      slot_tail[d] = 0;
      slot_fill[d] = 0;
      skip_irq[d] = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows; a new mask is written once the block has gone idle.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mask != usable_mask) begin
        drain();
        write_mask(directed_rows[i].mask);
      end
      send_word(directed_rows[i].kind, directed_rows[i].dev, directed_rows[i].blk,
                directed_rows[i].pinned, directed_rows[i].want);
    end

    foreach (phases[p]) begin
      drain();
      write_mask(phases[p].mask);
      sender_idle_pct = phases[p].idle_pct;
      recv_stall_pct = phases[p].stall_pct;
      run_random(phases[p].count);
    end

    drain();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("[disk_block_command_queue_top] OK");
    end else begin
      $display("[disk_block_command_queue_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/dbcq_pkg.sv
rtl/dbcq_in_if.sv
rtl/dbcq_out_if.sv
rtl/dbcq_front.sv
rtl/dbcq_cmd_fifo.sv
rtl/dbcq_back.sv
rtl/disk_block_command_queue_top.sv
rtl/dbcq_checker.sv
verif/tb_disk_block_command_queue_top.sv
